// File: sv/priority_scheduler_with_aging_core_defines.svh
// Assertion macros shared by the scheduler RTL
`ifndef PRIORITY_SCHEDULER_WITH_AGING_CORE_DEFINES_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, disabled while reset is low
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: sv/psa_pkg.sv
// Types and constants of the priority scheduler with aging
package psa_pkg;

    localparam int MAX_TASKS    = 16;
    localparam int AGING_PERIOD = 4;
    localparam int TASK_W       = $clog2(MAX_TASKS);
    localparam int COUNT_W      = $clog2(MAX_TASKS + 1);
    localparam int PHASE_W      = $clog2(AGING_PERIOD);
    localparam int OP_W         = 2;
    localparam int INDEX_W      = 8;
    localparam int STATUS_W     = 2;

    localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_W'(1 % AGING_PERIOD);
    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(AGING_PERIOD - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_TASKS);

    typedef enum logic [OP_W-1:0] {
        OP_ACTIVATE = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_AGING    = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic              remove;
        logic [TASK_W-1:0] target;
    } cell_ctrl_t;

endpackage

// File: sv/psa_cell.sv
// One cell of the arrival queue: holds a task index and shifts toward the head
module psa_cell
    import psa_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic              load,
    input  logic [TASK_W-1:0] load_data,
    input  logic              shift_in,
    input  logic [TASK_W-1:0] next_entry,
    output logic [TASK_W-1:0] entry,
    output logic              shift_out
);

    logic [TASK_W-1:0] entry_reg;

    assign entry     = entry_reg;
    assign shift_out = shift_in | (entry_reg == ctrl.target);

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= load_data;
        end else if (ctrl.remove && shift_out) begin
            entry_reg <= next_entry;
        end
    end

endmodule

// File: sv/priority_scheduler_with_aging_core.sv
// Priority scheduler with aging: ready bitmap, cell-chain arrival queue, control
// Latency: a result word appears the cycle after its request word is accepted.
// Throughput: one request word per cycle, held off by a stalled result or by cfg_we;
// the queue cell chain and the bitmap priority encoder are combinational.
// Reset (aresetn low, synchronous) resets the control state and sets num_tasks to 0.
// A num_tasks write clears the scheduler state in the same cycle.
`include "priority_scheduler_with_aging_core_defines.svh"

module priority_scheduler_with_aging_core
    import psa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [INDEX_W-1:0]  s_task_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [TASK_W-1:0]   m_running_task,
    output logic                m_running_valid,
    output logic [COUNT_W-1:0]  m_ready_count
);

    logic [COUNT_W-1:0]   num_tasks_reg;
    logic [MAX_TASKS-1:0] ready_map_reg,    ready_map_next;
    logic [COUNT_W-1:0]   ready_total_reg,  ready_total_next;
    logic [TASK_W-1:0]    current_task_reg, current_task_next;
    logic                 current_valid_reg, current_valid_next;
    logic [PHASE_W-1:0]   phase_reg,        phase_next;
    logic                 out_valid_reg;
    status_t              status_reg,       status_next;

    logic                 accept;
    op_t                  op_code;
    logic [TASK_W-1:0]    lowest;
    logic [TASK_W-1:0]    pick;
    logic                 aging_sel;
    logic                 append;
    cell_ctrl_t           cell_ctrl;
    logic [TASK_W-1:0]    entries [MAX_TASKS];
    logic [MAX_TASKS:0]   shift_chain;
    logic [COUNT_W-1:0]   map_count;
    logic [COUNT_W-1:0]   total_dec;
    logic                 dispatch_hit;

    assign s_ready = (!out_valid_reg || m_ready) && !cfg_we;
    assign accept  = s_valid && s_ready;
    assign op_code = op_t'(s_op);

    always_comb begin
        lowest = '0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (ready_map_reg[k]) begin
                lowest = TASK_W'(k);
            end
        end
    end

    always_comb begin
        ready_map_next     = ready_map_reg;
        ready_total_next   = ready_total_reg;
        current_task_next  = current_task_reg;
        current_valid_next = current_valid_reg;
        phase_next         = phase_reg;
        status_next        = STATUS_OK;
        aging_sel          = (op_code == OP_AGING) && (phase_reg == '0);
        pick               = aging_sel ? entries[0] : lowest;
        append             = 1'b0;
        cell_ctrl.remove   = 1'b0;
        cell_ctrl.target   = pick;
        unique case (op_code) inside
            OP_ACTIVATE: begin
                if (s_task_index >= INDEX_W'(num_tasks_reg)) begin
                    status_next = STATUS_RANGE;
                end else if (!ready_map_reg[s_task_index[TASK_W-1:0]]) begin
                    ready_map_next[s_task_index[TASK_W-1:0]] = 1'b1;
                    ready_total_next = ready_total_reg + COUNT_W'(1);
                    append           = accept;
                end
            end
            OP_DISPATCH, OP_AGING: begin
                if (ready_total_reg == '0) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    ready_map_next[pick] = 1'b0;
                    ready_total_next     = ready_total_reg - COUNT_W'(1);
                    current_task_next    = pick;
                    current_valid_next   = 1'b1;
                    phase_next           = (phase_reg == PHASE_LAST) ? '0 : phase_reg + PHASE_W'(1);
                    cell_ctrl.remove     = accept;
                end
            end
            default: ;
        endcase
    end

    assign shift_chain[0] = aging_sel;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        logic [TASK_W-1:0] next_entry;
        logic              load;

        assign next_entry = (k == MAX_TASKS - 1) ? entries[k] : entries[(k + 1) % MAX_TASKS];
        assign load       = append && (ready_total_reg[TASK_W-1:0] == TASK_W'(k));

        psa_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .load       (load),
            .load_data  (s_task_index[TASK_W-1:0]),
            .shift_in   (shift_chain[k]),
            .next_entry (next_entry),
            .entry      (entries[k]),
            .shift_out  (shift_chain[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_tasks_reg     <= '0;
            ready_map_reg     <= '0;
            ready_total_reg   <= '0;
            current_task_reg  <= '0;
            current_valid_reg <= 1'b0;
            phase_reg         <= PHASE_RESET;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_tasks_reg     <= (cfg_wdata > COUNT_MAX) ? COUNT_MAX : cfg_wdata;
                ready_map_reg     <= '0;
                ready_total_reg   <= '0;
                current_task_reg  <= '0;
                current_valid_reg <= 1'b0;
                phase_reg         <= PHASE_RESET;
            end else if (accept) begin
                ready_map_reg     <= ready_map_next;
                ready_total_reg   <= ready_total_next;
                current_task_reg  <= current_task_next;
                current_valid_reg <= current_valid_next;
                phase_reg         <= phase_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = status_reg;
    assign m_running_task  = current_task_reg;
    assign m_running_valid = current_valid_reg;
    assign m_ready_count   = ready_total_reg;

    assign map_count    = COUNT_W'($countones(ready_map_reg));
    assign total_dec    = ready_total_reg - COUNT_W'(1);
    assign dispatch_hit = accept && (op_code == OP_DISPATCH || op_code == OP_AGING)
                          && (ready_total_reg != '0);

    `PSA_ASSERT_NOW(a_count_matches_map, aclk, aresetn, 1'b1, ready_total_reg == map_count)
    `PSA_ASSERT_NOW(a_count_within_tasks, aclk, aresetn, 1'b1, ready_total_reg <= num_tasks_reg)
    `PSA_ASSERT_NOW(a_idle_task_zero, aclk, aresetn, !current_valid_reg, current_task_reg == '0)
    `PSA_ASSERT_NEXT(a_drop_one, aclk, aresetn, dispatch_hit, ready_total_reg == $past(total_dec))

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the priority scheduler with aging: a driver and a monitor
`timescale 1ns / 100ps

module tb_top;
    import psa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_WDATA  = 31;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
    } request_t;

    typedef struct {
        status_t            status;
        logic [TASK_W-1:0]  run_task;
        logic               run_valid;
        logic [COUNT_W-1:0] count;
    } sched_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [COUNT_W-1:0]  cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [INDEX_W-1:0]  s_task_index;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [TASK_W-1:0]   m_running_task;
    logic                m_running_valid;
    logic [COUNT_W-1:0]  m_ready_count;

    // predicted scheduler state
    int                  tasks_in_use;
    logic [MAX_TASKS-1:0] ready_bits;
    logic [TASK_W-1:0]   arrival[$];
    logic [TASK_W-1:0]   cur_task;
    logic                cur_valid;
    int                  switch_phase;

    request_t            requests_pending[$];
    sched_result_t       results_due[$];
    sched_result_t       want;
    request_t            word;
    int                  queued_total;
    int                  accepted_total;
    int                  errors;
    int                  send_gap;
    int                  stall_left;
    int                  idle_cycles;
    bit                  no_gaps;
    int                  settings_used;
    int                  dispatches;
    int                  aged_picks;
    int                  range_rejects;
    int                  empty_rejects;

    priority_scheduler_with_aging_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_index    (s_task_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_running_task  (m_running_task),
        .m_running_valid (m_running_valid),
        .m_ready_count   (m_ready_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void set_task_count(input int value);
        tasks_in_use = (value > MAX_TASKS) ? MAX_TASKS : value;
        ready_bits   = '0;
        arrival.delete();
        cur_task     = '0;
        cur_valid    = 1'b0;
        switch_phase = 1 % AGING_PERIOD;
    endfunction

    function automatic sched_result_t predict_request(input logic [OP_W-1:0] op,
                                                      input logic [INDEX_W-1:0] index);
        sched_result_t r;
        int pick;
        int pos;
        r.status = STATUS_OK;
        if (op == OP_ACTIVATE) begin
            if (index >= tasks_in_use) begin
                r.status = STATUS_RANGE;
                range_rejects++;
            end else if (!ready_bits[index[TASK_W-1:0]]) begin
                ready_bits[index[TASK_W-1:0]] = 1'b1;
                arrival.push_back(index[TASK_W-1:0]);
            end
        end else if (op == OP_DISPATCH || op == OP_AGING) begin
            if (arrival.size() == 0) begin
                r.status = STATUS_EMPTY;
                empty_rejects++;
            end else begin
                if (op == OP_AGING && switch_phase == 0) begin
                    pick = arrival.pop_front();
                    aged_picks++;
                end else begin
                    pick = 0;
                    while (!ready_bits[pick[TASK_W-1:0]]) pick++;
                    pos = 0;
                    while (arrival[pos] != pick) pos++;
                    arrival.delete(pos);
                end
                ready_bits[pick[TASK_W-1:0]] = 1'b0;
                cur_task     = pick[TASK_W-1:0];
                cur_valid    = 1'b1;
                switch_phase = (switch_phase + 1) % AGING_PERIOD;
                dispatches++;
            end
        end
        r.run_task  = cur_valid ? cur_task : '0;
        r.run_valid = cur_valid;
        r.count     = COUNT_W'(arrival.size());
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
        end
    endtask

    task automatic queue_request(input logic [OP_W-1:0] op, input int index);
        request_t item;
        item.op    = op;
        item.index = index[INDEX_W-1:0];
        requests_pending.push_back(item);
        queued_total++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (accepted_total != queued_total || results_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_task_count(input int value);
        wait_drained();
        repeat (2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[COUNT_W-1:0];
        set_task_count(value);
        settings_used++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int count);
        int k;
        int r;
        if (n > 0) begin
            for (k = 0; k < 2 * n; k++) queue_request(OP_ACTIVATE, $urandom_range(0, n - 1));
        end
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_request(OP_ACTIVATE, (n > 0) ? $urandom_range(0, n - 1)
                                                   : $urandom_range(0, 255));
            else if (r < 70)
                queue_request(OP_DISPATCH, $urandom_range(0, 255));
            else if (r < 92)
                queue_request(OP_AGING, $urandom_range(0, 255));
            else if (r < 97)
                queue_request(OP_ACTIVATE, $urandom_range(n, 255));
            else if (r < 99)
                queue_request(OP_ACTIVATE, $urandom_range(0, 255));
            else
                queue_request(OP_UNUSED, $urandom_range(0, 255));
            if (k == count / 2 && n % 2 == 0) wait_drained();
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (requests_pending.size() != 0) begin
                word = requests_pending.pop_front();
                s_valid      <= 1'b1;
                s_op         <= word.op;
                s_task_index <= word.index;
                send_gap = no_gaps ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result word with no request outstanding", $time);
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("running_task", want.run_task, m_running_task);
                    check_field("running_valid", want.run_valid, m_running_valid);
                    check_field("ready_count", want.count, m_ready_count);
                end
            end
            if (s_valid && s_ready) begin
                results_due.push_back(predict_request(s_op, s_task_index));
                accepted_total++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int settings[12];
        int p;
        settings     = '{16, 1, 2, 5, 16, 8, 17, 3, 12, 0, MAX_WDATA, 16};
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_op         = OP_ACTIVATE;
        s_task_index = '0;
        m_ready      = 1'b0;
        no_gaps      = 1'b0;
        set_task_count(0);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset state: nothing in range, nothing ready
        queue_request(OP_ACTIVATE, 0);
        queue_request(OP_DISPATCH, 0);
        queue_request(OP_AGING, 255);
        queue_request(OP_UNUSED, 0);

        // oversized write saturates to the full task count
        write_task_count(MAX_WDATA);
        queue_request(OP_ACTIVATE, 15);
        queue_request(OP_ACTIVATE, 0);
        queue_request(OP_ACTIVATE, 7);
        queue_request(OP_ACTIVATE, 15);
        queue_request(OP_ACTIVATE, 16);
        queue_request(OP_ACTIVATE, 255);
        queue_request(OP_ACTIVATE, 128);
        queue_request(OP_DISPATCH, 255);
        queue_request(OP_AGING, 0);
        queue_request(OP_AGING, 0);
        queue_request(OP_ACTIVATE, 3);
        queue_request(OP_ACTIVATE, 1);
        queue_request(OP_AGING, 0);
        queue_request(OP_DISPATCH, 0);
        queue_request(OP_DISPATCH, 0);
        queue_request(OP_AGING, 0);
        queue_request(OP_UNUSED, 255);
        queue_request(OP_ACTIVATE, 1);

        for (p = 0; p < 12; p++) begin
            write_task_count(settings[p]);
            no_gaps = (p % 3 == 1);
            random_phase(settings[p] > MAX_TASKS ? MAX_TASKS : settings[p], 50);
        end

        wait_drained();
        repeat (5) @(posedge aclk);
        $display("Ran %0d requests under %0d task-count settings, oversized writes included.",
                 accepted_total, settings_used);
        $display("%0d dispatches (%0d oldest-first), %0d range and %0d empty rejects.",
                 dispatches, aged_picks, range_rejects, empty_rejects);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/psa_pkg.sv
sv/psa_cell.sv
sv/priority_scheduler_with_aging_core.sv
verif/tb_top.sv
